// ===== design/psat_pkg.sv =====
// Shared constants and types for the polygon separating-axis overlap unit.
// No dependencies; psat_if, psat_proj and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none
package psat_pkg;

	localparam int FIELD_W          = 16;
	localparam int MAX_VERTS_DEF    = 16;
	localparam int COORD_BITS_DEF   = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_EDGE,
		ST_PROJ_P,
		ST_PROJ_Q,
		ST_DRAIN,
		ST_CHECK,
		ST_DONE
	} psat_state_t;

	// Control handed from the sequencer to the projection unit each cycle.
	typedef struct packed {
		logic issue;
		logic set_q;
		logic first;
		logic load_normal;
	} psat_proj_ctl_t;

endpackage
`default_nettype wire

// ===== design/psat_if.sv =====
// Handshake channels of the overlap unit: vertex requests in, results out.
// Depends on psat_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none
interface psat_vertex_if;
	import psat_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [FIELD_W-1:0]  vertex_x;
	logic signed [FIELD_W-1:0]  vertex_y;
	logic                       poly_id;
	logic                       end_pair;
	modport source (output valid, vertex_x, vertex_y, poly_id, end_pair, input ready);
	modport sink (input valid, vertex_x, vertex_y, poly_id, end_pair, output ready);
endinterface

interface psat_result_if;
	logic valid;
	logic ready;
	logic overlap;
	logic overflow;
	modport source (output valid, overlap, overflow, input ready);
	modport sink (input valid, overlap, overflow, output ready);
endinterface
`default_nettype wire

// ===== design/psat_cell.sv =====
// One storage cell of a vertex ring: loads a new vertex or takes its neighbor's.
// Depends on nothing but the clock.
`timescale 1ns / 1ps
`default_nettype none
module psat_cell #(
	parameter int VW = 32
) (
	input  wire logic          clk,
	input  wire logic          load_en,
	input  wire logic [VW-1:0] load_data,
	input  wire logic          shift_en,
	input  wire logic [VW-1:0] shift_data,
	output logic      [VW-1:0] data_q
);
	always_ff @(posedge clk) begin
		if (load_en) begin
			data_q <= load_data;
		end else if (shift_en) begin
			data_q <= shift_data;
		end
	end
endmodule
`default_nettype wire

// ===== design/psat_ring.sv =====
// Ring of vertex cells for one polygon; rotates over the filled cells only.
// Depends on psat_cell.
`timescale 1ns / 1ps
`default_nettype none
module psat_ring #(
	parameter int N  = 16,
	parameter int VW = 32,
	parameter int CNT_W = $clog2(N + 1)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [VW-1:0]    wr_data,
	input  wire logic [CNT_W-1:0] count,
	input  wire logic             shift_en,
	output logic      [VW-1:0]    head0,
	output logic      [VW-1:0]    head1
);
	logic [VW-1:0] cell_q [N];

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic          ld;
		logic [VW-1:0] nxt;
		// The last filled cell closes the ring by taking cell zero.
		assign ld  = wr_en && (count == CNT_W'(i));
		assign nxt = (count == CNT_W'(i + 1)) ? cell_q[0] : cell_q[(i + 1) % N];
		psat_cell #(.VW(VW)) u_cell (
			.clk        (clk),
			.load_en    (ld),
			.load_data  (wr_data),
			.shift_en   (shift_en),
			.shift_data (nxt),
			.data_q     (cell_q[i])
		);
	end

	assign head0 = cell_q[0];
	assign head1 = (count == CNT_W'(1)) ? cell_q[0] : cell_q[1];
endmodule
`default_nettype wire

// ===== design/psat_proj.sv =====
// Projection unit: dot product of one vertex with the axis normal, then
// running minimum and maximum per vertex set. Depends on psat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psat_proj #(
	parameter int C = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire psat_pkg::psat_proj_ctl_t ctl,
	input  wire logic signed [C-1:0]  px,
	input  wire logic signed [C-1:0]  py,
	input  wire logic signed [C:0]    nx,
	input  wire logic signed [C:0]    ny,
	output logic signed [2*C+1:0]     min_p_q,
	output logic signed [2*C+1:0]     max_p_q,
	output logic signed [2*C+1:0]     min_q_q,
	output logic signed [2*C+1:0]     max_q_q
);
	import psat_pkg::*;

	localparam int PW = 2 * C + 1;
	localparam int SW = 2 * C + 2;

	logic signed [C:0]    nx_q, ny_q;
	logic signed [PW-1:0] prod_x_s1, prod_y_s1;
	logic                 valid_s1, set_s1, first_s1;
	logic signed [SW-1:0] sum_s2;
	logic                 valid_s2, set_s2, first_s2;

	always_ff @(posedge clk) begin
		if (ctl.load_normal) begin
			nx_q <= nx;
			ny_q <= ny;
		end
		prod_x_s1 <= px * nx_q;
		prod_y_s1 <= py * ny_q;
		set_s1    <= ctl.set_q;
		first_s1  <= ctl.first;
		sum_s2    <= SW'(prod_x_s1) + SW'(prod_y_s1);
		set_s2    <= set_s1;
		first_s2  <= first_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && !set_s2) begin
			if (first_s2 || sum_s2 < min_p_q) begin
				min_p_q <= sum_s2;
			end
			if (first_s2 || sum_s2 > max_p_q) begin
				max_p_q <= sum_s2;
			end
		end
		if (valid_s2 && set_s2) begin
			if (first_s2 || sum_s2 < min_q_q) begin
				min_q_q <= sum_s2;
			end
			if (first_s2 || sum_s2 > max_q_q) begin
				max_q_q <= sum_s2;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/polygon_sat_overlap_unit.sv =====
// Top level of the separating-axis overlap unit for two convex polygons.
// Depends on psat_pkg, psat_if, psat_ring and psat_proj.
//
//  Channel    Dir  Payload                                  Meaning
//  vertices   in   vertex_x, vertex_y, poly_id, end_pair    one vertex request
//  results    out  overlap, overflow                        one result per pair
//
// A vertex request is taken only while the unit is idle. On end_pair the
// test runs on one projection unit as an edge loop over the edges of A, then
// of B, stopping on a separating axis; each edge projects the vertices of
// both through a three-stage multiply/add/compare pipeline. Reset clears counts,
// the drop flag and the sequencer; vertex cells are not reset. A stalled
// result sits in the output register while new vertices are still accepted;
// only a finished test waits for that register to free up.
`timescale 1ns / 1ps
`default_nettype none
module polygon_sat_overlap_unit #(
	parameter int MAX_VERTS  = psat_pkg::MAX_VERTS_DEF,
	parameter int COORD_BITS = psat_pkg::COORD_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	psat_vertex_if.sink    vertices,
	psat_result_if.source  results
);
	import psat_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int VW    = 2 * C;
	localparam int CNT_W = $clog2(MAX_VERTS + 1);

	psat_state_t      state_q, state_d;
	logic [CNT_W-1:0] count_a_q, count_b_q;
	logic             dropped_q;
	logic             phase_q;    // 0: edges of A, 1: edges of B
	logic [CNT_W-1:0] edge_q, step_q;
	logic             drain_q;
	logic             hit_q;
	logic             out_valid_q, out_overlap_q, out_overflow_q;

	logic             accept;
	logic [C-1:0]     raw_x, raw_y;
	logic             wr_a, wr_b;
	logic [VW-1:0]    a_head0, a_head1, b_head0, b_head1;
	logic [VW-1:0]    p_head0, p_head1, q_head0, src_vert;
	logic [CNT_W-1:0] pc, qc;
	logic signed [C:0] nx, ny;
	logic             zero_edge;
	logic             shift_p, shift_q, shift_a, shift_b;
	logic             separated, out_free;
	psat_proj_ctl_t   ctl;
	logic signed [2*C+1:0] min_p, max_p, min_q, max_q;

	// Coordinates are the low COORD_BITS of the field; wider coordinates see
	// the field bits zero-extended.
	always_comb begin
		for (int i = 0; i < C; i++) begin
			raw_x[i] = (i < FIELD_W) ? vertices.vertex_x[i % FIELD_W] : 1'b0;
			raw_y[i] = (i < FIELD_W) ? vertices.vertex_y[i % FIELD_W] : 1'b0;
		end
	end

	assign vertices.ready = (state_q == ST_IDLE);
	assign accept = vertices.valid && vertices.ready;
	assign wr_a = accept && !vertices.poly_id && (count_a_q != CNT_W'(MAX_VERTS));
	assign wr_b = accept && vertices.poly_id && (count_b_q != CNT_W'(MAX_VERTS));

	// Which ring supplies the edges and which is the other polygon.
	assign pc      = phase_q ? count_b_q : count_a_q;
	assign qc      = phase_q ? count_a_q : count_b_q;
	assign p_head0 = phase_q ? b_head0 : a_head0;
	assign p_head1 = phase_q ? b_head1 : a_head1;
	assign q_head0 = phase_q ? a_head0 : b_head0;

	// Integer edge normal (-dy, dx), left unnormalized.
	assign nx = {p_head0[VW-1], p_head0[VW-1:C]} - {p_head1[VW-1], p_head1[VW-1:C]};
	assign ny = {p_head1[C-1], p_head1[C-1:0]} - {p_head0[C-1], p_head0[C-1:0]};
	assign zero_edge = (nx == '0) && (ny == '0);

	assign shift_p = (state_q == ST_PROJ_P) || (state_q == ST_CHECK);
	assign shift_q = (state_q == ST_PROJ_Q);
	assign shift_a = phase_q ? shift_q : shift_p;
	assign shift_b = phase_q ? shift_p : shift_q;

	psat_ring #(.N(MAX_VERTS), .VW(VW), .CNT_W(CNT_W)) u_ring_a (
		.clk      (clk),
		.wr_en    (wr_a),
		.wr_data  ({raw_y, raw_x}),
		.count    (count_a_q),
		.shift_en (shift_a),
		.head0    (a_head0),
		.head1    (a_head1)
	);

	psat_ring #(.N(MAX_VERTS), .VW(VW), .CNT_W(CNT_W)) u_ring_b (
		.clk      (clk),
		.wr_en    (wr_b),
		.wr_data  ({raw_y, raw_x}),
		.count    (count_b_q),
		.shift_en (shift_b),
		.head0    (b_head0),
		.head1    (b_head1)
	);

	assign src_vert = (state_q == ST_PROJ_Q) ? q_head0 : p_head0;

	always_comb begin
		ctl.issue       = (state_q == ST_PROJ_P) || (state_q == ST_PROJ_Q);
		ctl.set_q       = (state_q == ST_PROJ_Q);
		ctl.first       = (step_q == '0);
		ctl.load_normal = (state_q == ST_EDGE);
	end

	psat_proj #(.C(C)) u_proj (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.px      (src_vert[C-1:0]),
		.py      (src_vert[VW-1:C]),
		.nx      (nx),
		.ny      (ny),
		.min_p_q (min_p),
		.max_p_q (max_p),
		.min_q_q (min_q),
		.max_q_q (max_q)
	);

	// Touching intervals still count as overlapping.
	assign separated = (max_q < min_p) || (max_p < min_q);
	assign out_free  = !out_valid_q || results.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && vertices.end_pair) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (count_a_q == '0 || count_b_q == '0) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_EDGE;
				end
			end
			ST_EDGE: begin
				state_d = zero_edge ? ST_DONE : ST_PROJ_P;
			end
			ST_PROJ_P: begin
				if (step_q == pc - CNT_W'(1)) begin
					state_d = ST_PROJ_Q;
				end
			end
			ST_PROJ_Q: begin
				if (step_q == qc - CNT_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (separated || (edge_q == pc - CNT_W'(1) && phase_q)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_EDGE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Loop counters and the verdict of the running test.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			edge_q  <= '0;
			step_q  <= '0;
			drain_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_START: begin
					phase_q <= 1'b0;
					edge_q  <= '0;
					hit_q   <= 1'b0;
				end
				ST_EDGE: begin
					step_q <= '0;
				end
				ST_PROJ_P: begin
					step_q <= (step_q == pc - CNT_W'(1)) ? '0 : step_q + CNT_W'(1);
				end
				ST_PROJ_Q: begin
					step_q  <= step_q + CNT_W'(1);
					drain_q <= 1'b0;
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
				end
				ST_CHECK: begin
					if (edge_q == pc - CNT_W'(1)) begin
						edge_q  <= '0;
						phase_q <= 1'b1;
						hit_q   <= !separated && phase_q;
					end else begin
						edge_q <= edge_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Vertex counts and the drop flag; both clear once the result is out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q <= '0;
			count_b_q <= '0;
			dropped_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			count_a_q <= '0;
			count_b_q <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (wr_a) begin
				count_a_q <= count_a_q + CNT_W'(1);
			end
			if (wr_b) begin
				count_b_q <= count_b_q + CNT_W'(1);
			end
			if (accept && !wr_a && !wr_b) begin
				dropped_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_overlap_q  <= hit_q;
			out_overflow_q <= dropped_q;
		end
	end

	assign results.valid    = out_valid_q;
	assign results.overlap  = out_overlap_q;
	assign results.overflow = out_overflow_q;
endmodule
`default_nettype wire
